// ===== design/blob_ovl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the blob outline overlay: channel payload structs, register
// indexes, class codes and the blend helper. No dependencies.
package blob_ovl_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int CH_W      = 8;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;
  localparam int DIM_W     = 13;   // holds any frame dimension up to 4096
  localparam int THR_W     = 8;
  localparam int FW_W      = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd213;
  localparam logic [FW_W-1:0]  WIDTH_RST     = 11'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 13'd1024;

  localparam logic [CH_W-1:0] CH_FULL = 8'd255;

  // floor(x/5) for x < 1280 equals (x * 13108) >> 16
  localparam logic [14:0] RECIP5 = 15'd13108;

  typedef enum logic [1:0] {
    CLS_BORDER   = 2'd0,
    CLS_EDGE     = 2'd1,
    CLS_INTERIOR = 2'd2
  } edge_class_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic            frame_start;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic [1:0]           edge_class;
    logic                 last_of_item;
  } out_item_t;

  // (4*orig + overlay)/5, truncated
  function automatic logic [CH_W-1:0] blend5(input logic [CH_W-1:0] orig,
                                             input logic [CH_W-1:0] ovl_lvl);
    logic [10:0] x;
    logic [25:0] p;
    x = {1'b0, orig, 2'b00} + {3'b000, ovl_lvl};
    p = 26'(x) * 26'(RECIP5);
    return p[23:16];
  endfunction

endpackage

// ===== design/blob_outline_overlay_core.sv =====
`timescale 1ns / 1ps
// Top level of the blob outline overlay: line store, 4-neighbor edge
// classification, result queue and blend output. Uses blob_ovl_pkg.
//
//  channel | ports                       | moves
//  --------+-----------------------------+----------------------------------
//  input   | in_valid/in_ready/in_data   | one RGB pixel, raster order
//  result  | out_valid/out_ready/out_data| overlay pixel with coordinates
//  config  | cfg_valid/cfg_ready/cfg_*   | register write, always ready
//
// One pixel per cycle while out_ready holds and each pixel yields at most one
// result; the single result port delivers one result per cycle, so last-row
// pixels (up to three results each) and row ends pace the input through the
// 8-entry queue. Path: stage 1, result queue, output register. Line store read
// and write-back sit in adjacent stages; a same-column overlap is forwarded.
// Reset clears counters, queue and registers; the line store is not cleared.
module blob_outline_overlay_core #(
  parameter int MAX_WIDTH = blob_ovl_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  blob_ovl_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output blob_ovl_pkg::out_item_t                out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [blob_ovl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blob_ovl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import blob_ovl_pkg::*;

  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ENTRY_W    = 26;
  localparam int BIN_BIT    = 24;
  localparam int UP_BIT     = 25;
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int RDY_LIM    = FIFO_DEPTH - 2 * MAX_RES;

  typedef struct packed {
    logic [23:0]          rgb;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    edge_class_t          cls;
    logic                 last;
  } res_t;

  // configuration
  logic [THR_W-1:0] thr_r;
  logic [FW_W-1:0]  fw_r;
  logic [DIM_W-1:0] fh_r;

  // position counters
  logic [COL_W-1:0]     col_cnt_r, col_cnt_nxt;
  logic [OUT_ROW_W-1:0] row_cnt_r, row_cnt_nxt;

  // stage 0
  logic                 in_fire;
  logic [DIM_W-1:0]     w_eff, h_eff, fw_ext;
  logic [COL_W-1:0]     c0;
  logic [OUT_ROW_W-1:0] r0;
  logic [DIM_W-1:0]     r_tmp, r_inc;
  logic                 col_last;
  logic [9:0]           px_sum, thr3;

  // stage 1
  logic                 s1_valid_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [OUT_ROW_W-1:0] s1_row_r;
  logic [23:0]          s1_rgb_r;
  logic                 s1_bin_r;
  logic                 s1_emit_a_r, s1_border_r, s1_emit_b_r, s1_emit_c_r;
  logic [ENTRY_W-1:0]   rd_data_r, fwd_data_r, cc, wdata;
  logic                 fwd_r;
  logic [ENTRY_W-1:0]   win_a_r, win_b_r;
  logic                 prev_bin_r;

  logic [ENTRY_W-1:0]   line_mem [MAX_WIDTH];

  // result queue
  res_t                 fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     count_r;
  res_t                 res0, res1, res2;
  res_t                 slot [MAX_RES];
  logic [1:0]           push_n;
  logic                 pop;
  res_t                 head;
  logic                 ctr, is_edge;

  // output register
  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic [CH_W-1:0]      ovl_r, ovl_gb;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r <= CNT_W'(RDY_LIM));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- stage 0: position and binarize ----------------
  always_comb begin
    fw_ext = DIM_W'(fw_r);
    if (fw_ext < DIM_W'(3))              w_eff = DIM_W'(3);
    else if (fw_ext > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else                                 w_eff = fw_ext;
    if (fh_r < DIM_W'(3))                 h_eff = DIM_W'(3);
    else if (fh_r > DIM_W'(MAX_HEIGHT))   h_eff = DIM_W'(MAX_HEIGHT);
    else                                  h_eff = fh_r;

    if (in_data.frame_start) begin
      c0    = '0;
      r_tmp = '0;
    end else if (DIM_W'(col_cnt_r) >= w_eff) begin
      c0    = '0;
      r_tmp = DIM_W'(row_cnt_r) + DIM_W'(1);
    end else begin
      c0    = col_cnt_r;
      r_tmp = DIM_W'(row_cnt_r);
    end
    r0 = (r_tmp >= h_eff) ? '0 : r_tmp[OUT_ROW_W-1:0];

    col_last = (DIM_W'(c0) == w_eff - DIM_W'(1));
    r_inc    = DIM_W'(r0) + DIM_W'(1);
    if (col_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc >= h_eff) ? '0 : r_inc[OUT_ROW_W-1:0];
    end else begin
      col_cnt_nxt = c0 + COL_W'(1);
      row_cnt_nxt = r0;
    end

    // gray > thr  <=>  r+g+b >= 3*(thr+1)
    px_sum = 10'(in_data.in_red) + 10'(in_data.in_green) + 10'(in_data.in_blue);
    thr3   = {1'b0, thr_r, 1'b0} + 10'(thr_r) + 10'd3;
  end

  // ---------------- line store ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= line_mem[c0];
    end
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wdata;
    end
  end

  // ---------------- stage 1: classify ----------------
  assign cc    = fwd_r ? fwd_data_r : rd_data_r;
  assign wdata = {cc[BIN_BIT], s1_bin_r, s1_rgb_r};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r    <= c0;
      s1_row_r    <= r0;
      s1_rgb_r    <= {in_data.in_blue, in_data.in_green, in_data.in_red};
      s1_bin_r    <= (px_sum >= thr3);
      s1_emit_a_r <= (r0 != '0) && (c0 != '0);
      s1_border_r <= (r0 == OUT_ROW_W'(1)) || (c0 == COL_W'(1));
      s1_emit_b_r <= (r0 != '0) && col_last;
      s1_emit_c_r <= (DIM_W'(r0) == h_eff - DIM_W'(1));
    end
    fwd_data_r <= wdata;
    if (s1_valid_r) begin
      win_a_r    <= win_b_r;
      win_b_r    <= cc;
      prev_bin_r <= s1_bin_r;
    end
  end

  always_comb begin
    ctr     = win_b_r[BIN_BIT];
    is_edge = (ctr != win_a_r[BIN_BIT]) || (ctr != cc[BIN_BIT]) ||
              (ctr != win_b_r[UP_BIT]) || (ctr != prev_bin_r);

    res0.rgb  = win_b_r[23:0];
    res0.col  = OUT_COL_W'(s1_col_r - COL_W'(1));
    res0.row  = s1_row_r - OUT_ROW_W'(1);
    res0.cls  = s1_border_r ? CLS_BORDER : (is_edge ? CLS_EDGE : CLS_INTERIOR);
    res0.last = 1'b0;

    res1.rgb  = cc[23:0];
    res1.col  = OUT_COL_W'(s1_col_r);
    res1.row  = s1_row_r - OUT_ROW_W'(1);
    res1.cls  = CLS_BORDER;
    res1.last = 1'b0;

    res2.rgb  = s1_rgb_r;
    res2.col  = OUT_COL_W'(s1_col_r);
    res2.row  = s1_row_r;
    res2.cls  = CLS_BORDER;
    res2.last = 1'b0;

    // pack present results into consecutive queue slots
    slot[0] = s1_emit_a_r ? res0 : (s1_emit_b_r ? res1 : res2);
    slot[1] = (s1_emit_a_r && s1_emit_b_r) ? res1 : res2;
    slot[2] = res2;
    push_n  = s1_valid_r ? (2'(s1_emit_a_r) + 2'(s1_emit_b_r) + 2'(s1_emit_c_r))
                         : 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      if (push_n == 2'(k + 1)) begin
        slot[k].last = 1'b1;
      end
    end
  end

  // ---------------- result queue ----------------
  assign pop  = (count_r != '0) && (!out_valid_r || out_ready);
  assign head = fifo_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < push_n) begin
        fifo_mem[wr_ptr_r + PTR_W'(k)] <= slot[k];
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    ovl_r  = (head.cls != CLS_BORDER) ? CH_FULL : '0;
    ovl_gb = (head.cls == CLS_INTERIOR) ? CH_FULL : '0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.out_red      <= blend5(head.rgb[7:0], ovl_r);
      out_data_r.out_green    <= blend5(head.rgb[15:8], ovl_gb);
      out_data_r.out_blue     <= blend5(head.rgb[23:16], ovl_gb);
      out_data_r.out_col      <= head.col;
      out_data_r.out_row      <= head.row;
      out_data_r.edge_class   <= head.cls;
      out_data_r.last_of_item <= head.last;
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      fw_r        <= WIDTH_RST;
      fh_r        <= HEIGHT_RST;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
          CFG_WIDTH:     fw_r  <= cfg_data[FW_W-1:0];
          CFG_HEIGHT:    fh_r  <= cfg_data;
          default:       ;
        endcase
      end
      if (in_fire) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      s1_valid_r <= in_fire;
      // new read hits the column being written back this cycle
      fwd_r      <= s1_valid_r && in_fire && (c0 == s1_col_r);
      wr_ptr_r   <= wr_ptr_r + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push_n) - CNT_W'(pop);
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/blob_ovl_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for blob_outline_overlay_core: watches the pixel, result and
// register channels, predicts the overlay results and compares them in order.
// Depends on blob_ovl_pkg.
module blob_ovl_checker #(
  parameter int MAX_W = blob_ovl_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  blob_ovl_pkg::in_item_t              in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  blob_ovl_pkg::out_item_t             out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [blob_ovl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blob_ovl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatch_cnt,
  output int                                  pending
);
  import blob_ovl_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic [FW_W-1:0]  width_q;
  logic [DIM_W-1:0] height_q;

  // per column: {bin of pixel above, bin, blue, green, red}
  logic [25:0] row_mem [MAX_W];
  logic [25:0] win_left;   // row above, column c-2
  logic [25:0] win_mid;    // row above, column c-1
  int          col_q;
  int          row_q;
  int          miss;

  out_item_t   overlay_q [$];

  initial begin
    for (int k = 0; k < MAX_W; k++) row_mem[k] = '0;
  end

  function automatic out_item_t make_overlay(input logic [23:0] rgb, input int col,
                                             input int row, input edge_class_t cls);
    int        ovl_r;
    int        ovl_gb;
    out_item_t o;
    ovl_r  = (cls == CLS_BORDER) ? 0 : 255;
    ovl_gb = (cls == CLS_INTERIOR) ? 255 : 0;
    o.out_red      = 8'((4 * int'(rgb[7:0]) + ovl_r) / 5);
    o.out_green    = 8'((4 * int'(rgb[15:8]) + ovl_gb) / 5);
    o.out_blue     = 8'((4 * int'(rgb[23:16]) + ovl_gb) / 5);
    o.out_col      = OUT_COL_W'(col);
    o.out_row      = OUT_ROW_W'(row);
    o.edge_class   = cls;
    o.last_of_item = 1'b0;
    return o;
  endfunction

  task automatic predict_pixel(input in_item_t px);
    int          w;
    int          h;
    int          c;
    int          r;
    int          gray;
    int          n;
    logic        bin;
    logic        ctr;
    logic [25:0] a;
    logic [25:0] b;
    logic [25:0] cc;
    edge_class_t cls;
    out_item_t   res [3];
    w = int'(width_q);
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    h = int'(height_q);
    if (h < 3) h = 3;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;

    c = col_q;
    r = row_q;
    if (px.frame_start) begin
      c = 0;
      r = 0;
    end else if (c >= w) begin
      c = 0;
      r = r + 1;
    end
    if (r >= h) r = 0;

    gray = (int'(px.in_red) + int'(px.in_green) + int'(px.in_blue)) / 3;
    bin  = (gray > int'(thr_q));

    a  = win_left;
    b  = win_mid;
    cc = row_mem[c];
    row_mem[c] = {cc[24], bin, px.in_blue, px.in_green, px.in_red};
    win_left = b;
    win_mid  = cc;

    // output lags one row: (c-1, r-1) is centered on b
    n = 0;
    if (r >= 1 && c >= 1) begin
      if (r == 1 || c == 1) begin
        cls = CLS_BORDER;
      end else begin
        ctr = b[24];
        if (a[24] != ctr || cc[24] != ctr || b[25] != ctr || row_mem[c-1][24] != ctr)
          cls = CLS_EDGE;
        else
          cls = CLS_INTERIOR;
      end
      res[n] = make_overlay(b[23:0], c - 1, r - 1, cls);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      res[n] = make_overlay(cc[23:0], c, r - 1, CLS_BORDER);
      n++;
    end
    if (r == h - 1) begin
      res[n] = make_overlay({px.in_blue, px.in_green, px.in_red}, c, r, CLS_BORDER);
      n++;
    end
    if (n > 0) res[n-1].last_of_item = 1'b1;
    for (int k = 0; k < n; k++) overlay_q.push_back(res[k]);

    if (c == w - 1) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
      row_q = r;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      thr_q    = THRESHOLD_RST;
      width_q  = WIDTH_RST;
      height_q = HEIGHT_RST;
      win_left = '0;
      win_mid  = '0;
      col_q    = 0;
      row_q    = 0;
      miss     = 0;
      overlay_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_q    = cfg_data[THR_W-1:0];
          CFG_WIDTH:     width_q  = cfg_data[FW_W-1:0];
          CFG_HEIGHT:    height_q = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (overlay_q.size() == 0) begin
          miss++;
          if (miss <= 10)
            $display("blob_ovl_checker: unexpected result col %0d row %0d cls %0d",
                     out_data.out_col, out_data.out_row, out_data.edge_class);
        end else begin
          want = overlay_q.pop_front();
          if (out_data.out_red !== want.out_red || out_data.out_green !== want.out_green ||
              out_data.out_blue !== want.out_blue || out_data.out_col !== want.out_col ||
              out_data.out_row !== want.out_row ||
              out_data.edge_class !== want.edge_class ||
              out_data.last_of_item !== want.last_of_item) begin
            miss++;
            if (miss <= 10)
              $display({"blob_ovl_checker: mismatch exp rgb %0d/%0d/%0d at (%0d,%0d) cls %0d",
                        " last %0d, got rgb %0d/%0d/%0d at (%0d,%0d) cls %0d last %0d"},
                       want.out_red, want.out_green, want.out_blue, want.out_col,
                       want.out_row, want.edge_class, want.last_of_item,
                       out_data.out_red, out_data.out_green, out_data.out_blue,
                       out_data.out_col, out_data.out_row, out_data.edge_class,
                       out_data.last_of_item);
          end
        end
      end
      if (in_valid && in_ready) predict_pixel(in_data);
    end
    mismatch_cnt <= miss;
    pending      <= overlay_q.size();
  end

endmodule

// ===== tb/blob_outline_overlay_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the blob_outline_overlay_core testbench: clock, reset, register writes
// and pixel stimulus with random idling; checking is done in blob_ovl_checker.
// Depends on blob_ovl_pkg, blob_ovl_checker and the RTL.
module blob_outline_overlay_core_tb;
  import blob_ovl_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DIR_LEN     = 25;
  // long result hold-off starts once this many pixels went in (inside the 5x4 frame)
  localparam int HOLD_AT     = 8;
  // binary value of each directed pixel, first pixel in bit 0 (5x4 frame + 5)
  localparam logic [DIR_LEN-1:0] DIR_MAP = 25'h0D04EFF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    mismatch_cnt;
  int                    pending;
  int                    px_sent = 0;
  int                    cycles = 0;
  logic [THR_W-1:0]      thr_now = THRESHOLD_RST;

  blob_outline_overlay_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blob_ovl_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatch_cnt (mismatch_cnt),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("blob_outline_overlay_core_tb: errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic in_item_t dir_pixel(input int k);
    logic [23:0] rgb;
    if (DIR_MAP[k]) begin
      case (k % 4)
        0:       rgb = {8'd255, 8'd255, 8'd255};
        1:       rgb = {8'd101, 8'd101, 8'd101};
        2:       rgb = {8'd0, 8'd255, 8'd255};
        default: rgb = {8'd200, 8'd50, 8'd60};
      endcase
    end else begin
      case (k % 4)
        0:       rgb = {8'd0, 8'd0, 8'd0};
        1:       rgb = {8'd100, 8'd100, 8'd100};
        2:       rgb = {8'd255, 8'd0, 8'd0};
        default: rgb = {8'd102, 8'd101, 8'd99};   // gray 100, just at threshold
      endcase
    end
    // frame start on the first pixel and once more in the middle of a frame
    return {rgb, (k == 0 || k == 23)};
  endfunction

  function automatic in_item_t rand_pixel(input logic fs);
    in_item_t px;
    int       v;
    case ($urandom_range(0, 3))
      0: begin
        // gray right around the threshold
        v = int'(thr_now) + int'($urandom_range(0, 3)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        px = {8'(v), 8'(v), 8'(v), fs};
      end
      1: begin
        px.in_red   = $urandom_range(0, 1) ? CH_FULL : 8'd0;
        px.in_green = $urandom_range(0, 1) ? CH_FULL : 8'd0;
        px.in_blue  = $urandom_range(0, 1) ? CH_FULL : 8'd0;
        px.frame_start = fs;
      end
      default: px = {8'($urandom), 8'($urandom), 8'($urandom), fs};
    endcase
    return px;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) thr_now = val[THR_W-1:0];
    @(posedge clk);
  endtask

  // wait until every predicted result is out, then let the pipeline drain
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_pixel(input in_item_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    px_sent++;
  endtask

  task automatic run_phase(input int n_px, input bit directed, input bit first_fs,
                           input int fs_pct);
    int gap;
    int calm;
    calm = 0;
    for (int k = 0; k < n_px; k++) begin
      if (directed)
        send_pixel(dir_pixel(k));
      else
        send_pixel(rand_pixel((k == 0 && first_fs) || ($urandom_range(0, 99) < fs_pct)));
      if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 29) == 0) calm = 40;
      end
      if (gap > 0 || k == n_px - 1) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    bit hold_done;
    int stall;
    int run;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && px_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        stall = 400;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      // ready stretch, cut short when the hold-off point comes up
      run = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      do begin
        @(posedge clk);
        run--;
      end while (run > 0 && (hold_done || px_sent < HOLD_AT));
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed 5x4 frame with interior, edge and border pixels
    write_reg(CFG_THRESHOLD, 13'd100);
    write_reg(CFG_WIDTH, 13'd5);
    write_reg(CFG_HEIGHT, 13'd4);
    run_phase(DIR_LEN, 1'b1, 1'b1, 0);

    // threshold 0 with junk in the upper data bits, sizes clamped up to 3x3
    wait_idle();
    write_reg(CFG_THRESHOLD, 13'h1F00);
    write_reg(CFG_WIDTH, 13'h1802);
    write_reg(CFG_HEIGHT, 13'h0000);
    run_phase(30, 1'b0, 1'b1, 3);

    // threshold 255, narrowest width, tallest height
    wait_idle();
    write_reg(CFG_THRESHOLD, 13'h00FF);
    write_reg(CFG_WIDTH, 13'd3);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    run_phase(24, 1'b0, 1'b1, 0);

    // stop at column 6 row 2 of 8x6, shrink width so the column wraps,
    // stop at column 2 of row 5, shrink height so the row wraps
    wait_idle();
    write_reg(CFG_THRESHOLD, 13'($urandom_range(0, 255)));
    write_reg(CFG_WIDTH, 13'd8);
    write_reg(CFG_HEIGHT, 13'd6);
    run_phase(22, 1'b0, 1'b1, 0);
    wait_idle();
    write_reg(CFG_WIDTH, 13'd4);
    run_phase(10, 1'b0, 1'b0, 0);
    wait_idle();
    write_reg(CFG_HEIGHT, 13'd3);
    run_phase(12, 1'b0, 1'b0, 0);

    // widths stay within the columns already filled by the 8x6 frame
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_reg(CFG_THRESHOLD, 13'($urandom_range(0, 255)));
      write_reg(CFG_WIDTH, 13'($urandom_range(3, 8)));
      write_reg(CFG_HEIGHT, 13'($urandom_range(3, 8)));
      run_phase(27, 1'b0, 1'b1, 3);
    end

    wait_idle();
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("blob_outline_overlay_core_tb: clean");
    end else begin
      $display("blob_outline_overlay_core_tb: errors");
    end
    $finish;
  end

endmodule
